// File: rtl/glc_pkg.sv
package glc_pkg;

  // Cursor coordinate width; coordinates saturate at all ones.
  localparam int CURSOR_BITS = 16;
  localparam int SCALE_BITS  = 5;
  // Width of the cursor times scale product, never narrower than a destination field.
  localparam int PROD_W      = (CURSOR_BITS + SCALE_BITS > 20) ? CURSOR_BITS + SCALE_BITS : 20;

  typedef logic [CURSOR_BITS-1:0] cursor_t;

  // Configuration register indexes.
  localparam logic [1:0] CFG_ORIGIN_X = 2'd0;
  localparam logic [1:0] CFG_ORIGIN_Y = 2'd1;
  localparam logic [1:0] CFG_SCALE    = 2'd2;

  // Colour indexes.
  localparam logic [2:0] INK_WHITE  = 3'd0;
  localparam logic [2:0] INK_RED    = 3'd1;
  localparam logic [2:0] INK_GREEN  = 3'd2;
  localparam logic [2:0] INK_PURPLE = 3'd3;
  localparam logic [2:0] INK_BLUE   = 3'd4;
  localparam logic [2:0] INK_GRAY   = 3'd5;
  localparam logic [2:0] INK_YELLOW = 3'd6;
  localparam logic [2:0] INK_ORANGE = 3'd7;

  // Glyph used for any character without an atlas entry.
  localparam logic [6:0] GLYPH_UNKNOWN = 7'd44;

  // Cursor steps.
  localparam logic [3:0] STEP_NEWLINE = 4'd8;
  localparam logic [3:0] STEP_SPACE   = 4'd5;
  localparam logic [3:0] STEP_TAB     = 4'd10;
  localparam logic [3:0] STEP_NARROW  = 4'd6;
  localparam logic [3:0] STEP_WIDE    = 4'd8;

  localparam logic [10:0] SRC_X_BASE = 11'd480;

  typedef enum logic [2:0] {
    KIND_GLYPH,
    KIND_NEWLINE,
    KIND_SPACE,
    KIND_TAB,
    KIND_MARKER
  } kind_t;

  // Classification of one folded code point.
  typedef struct packed {
    kind_t      kind;
    logic [6:0] glyph;
    logic [2:0] color;
    logic       wide;
  } dec_t;

  typedef struct packed {
    logic [20:0] code_point;
    logic        first;
  } in_item_t;

  typedef struct packed {
    logic [6:0]  glyph_index;
    logic [10:0] src_x;
    logic [19:0] dst_x;
    logic [19:0] dst_y;
    logic [7:0]  dst_w;
    logic [6:0]  dst_h;
    logic [2:0]  color_index;
  } out_item_t;

  // Cursor addition that sticks at the largest coordinate.
  function automatic cursor_t sat_add(cursor_t a, logic [3:0] b);
    logic [CURSOR_BITS:0] sum;
    sum = {1'b0, a} + (CURSOR_BITS + 1)'(b);
    if (sum[CURSOR_BITS]) begin
      return {CURSOR_BITS{1'b1}};
    end
    return sum[CURSOR_BITS-1:0];
  endfunction

endpackage

// File: rtl/glc_decode.sv
module glc_decode (
  input  logic [20:0]  code_point,
  output glc_pkg::dec_t dec
);
  import glc_pkg::*;

  logic [20:0] c;

  // Fold ASCII, Cyrillic and Cyrillic extended capitals to lower case.
  always_comb begin
    c = code_point;
    if (code_point >= 21'h41 && code_point <= 21'h5A) begin
      c = code_point + 21'h20;
    end else if (code_point >= 21'h410 && code_point <= 21'h42F) begin
      c = code_point + 21'h20;
    end else if (code_point >= 21'h400 && code_point <= 21'h40F) begin
      c = code_point + 21'h50;
    end
  end

  // Control characters, colour markers and the atlas lookup.
  always_comb begin
    dec.kind  = KIND_GLYPH;
    dec.glyph = GLYPH_UNKNOWN;
    dec.color = INK_WHITE;
    dec.wide  = 1'b0;

    case (c)
      21'h0A:   dec.kind = KIND_NEWLINE;
      21'h20:   dec.kind = KIND_SPACE;
      21'h09:   dec.kind = KIND_TAB;
      21'h5C:   begin dec.kind = KIND_MARKER; dec.color = INK_RED;    end
      21'h40:   begin dec.kind = KIND_MARKER; dec.color = INK_GREEN;  end
      21'h26:   begin dec.kind = KIND_MARKER; dec.color = INK_PURPLE; end
      21'h2F:   begin dec.kind = KIND_MARKER; dec.color = INK_BLUE;   end
      21'h7C:   begin dec.kind = KIND_MARKER; dec.color = INK_GRAY;   end
      21'h60:   begin dec.kind = KIND_MARKER; dec.color = INK_YELLOW; end
      21'h7E:   begin dec.kind = KIND_MARKER; dec.color = INK_WHITE;  end
      21'h2116: begin dec.kind = KIND_MARKER; dec.color = INK_ORANGE; end
      default:  dec.kind = KIND_GLYPH;
    endcase

    // Punctuation, digits, private use symbols and letters.
    case (c)
      21'h2D, 21'h5F, 21'h2013, 21'h2014: dec.glyph = 7'd26;
      21'h22:                             dec.glyph = 7'd39;
      21'h3B:                             dec.glyph = 7'd40;
      21'h2C:                             dec.glyph = 7'd27;
      21'h31:                             dec.glyph = 7'd28;
      21'h32:                             dec.glyph = 7'd29;
      21'h33:                             dec.glyph = 7'd30;
      21'h34:                             dec.glyph = 7'd31;
      21'h35:                             dec.glyph = 7'd32;
      21'h36:                             dec.glyph = 7'd33;
      21'h37:                             dec.glyph = 7'd34;
      21'h38:                             dec.glyph = 7'd35;
      21'h39:                             dec.glyph = 7'd36;
      21'h30:                             dec.glyph = 7'd37;
      21'h21, 21'h2E:                     dec.glyph = 7'd38;
      21'h27:                             dec.glyph = 7'd39;
      21'h3A:                             dec.glyph = 7'd40;
      21'h28, 21'h5B, 21'h3C:             dec.glyph = 7'd41;
      21'h29, 21'h5D, 21'h3E:             dec.glyph = 7'd42;
      21'h25:                             dec.glyph = 7'd43;
      21'h2B:                             dec.glyph = 7'd77;
      21'hE000:                           dec.glyph = 7'd79;
      21'hE001:                           dec.glyph = 7'd77;
      21'hE002:                           dec.glyph = 7'd80;
      21'hE003, 21'hE004:                 dec.glyph = 7'd26;
      21'hE005, 21'hE007:                 dec.glyph = 7'd44;
      21'hE006:                           dec.glyph = 7'd39;
      21'hE008:                           dec.glyph = 7'd41;
      21'hE009:                           dec.glyph = 7'd42;
      21'h451:                            dec.glyph = 7'd50;
      default: begin
        if (c >= 21'd97 && c <= 21'd122) begin
          dec.glyph = 7'(c - 21'd97);
        end else if (c >= 21'h430 && c <= 21'h44F) begin
          dec.glyph = 7'(c - 21'h430 + 21'd45);
        end else begin
          dec.glyph = GLYPH_UNKNOWN;
        end
      end
    endcase

    // Glyphs that take the wider advance.
    case (c)
      21'h77, 21'h6D, 21'h78, 21'h6E,
      21'h43C, 21'h434, 21'h438, 21'h439, 21'h44E,
      21'h44C, 21'h43B, 21'h448, 21'h449, 21'h446, 21'h436: dec.wide = 1'b1;
      default: dec.wide = 1'b0;
    endcase
  end

endmodule

// File: rtl/glyph_layout_cursor_unit.sv
// Text label layout: one Unicode code point in, at most one blit command out.
//
// Input channel in_valid/in_ready/in_item carries the code point and a flag
// marking the first character of a label, which puts the cursor back at the
// origin and the colour to white. Output channel out_valid/out_ready/out_item
// carries a blit command (atlas glyph, source x, scaled destination rectangle,
// colour index) for every drawing character. Newline, space, tab and the
// colour markers update the cursor or colour and give no command.
//
// An item is taken into an input register, decoded and placed into the output
// register once that is free, so a command is shown from the output register.
// One item per cycle is sustained while the receiver keeps up; the cursor update
// is a single saturating add done in the same cycle as the decode.
// When the receiver stalls, a drawing item waits in the input register and
// in_ready falls; non-drawing items still pass.
// Reset empties both registers, puts the cursor at zero, the colour to white,
// both origins to zero and the scale to one. The cfg port writes origin_x, origin_y
// and scale by index; the user must write only while the block is idle (not enforced).
module glyph_layout_cursor_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  glc_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output glc_pkg::out_item_t  out_item,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [11:0]         cfg_data
);
  import glc_pkg::*;

  logic [11:0] origin_x;
  logic [11:0] origin_y;
  logic [4:0]  scale;

  cursor_t     cursor_x;
  cursor_t     cursor_y;
  logic [2:0]  current_color;
  cursor_t     cursor_x_next;
  cursor_t     cursor_y_next;
  logic [2:0]  current_color_next;

  logic        s1_valid;
  in_item_t    s1_item;
  dec_t        dec;

  cursor_t     base_x;
  cursor_t     base_y;
  logic [2:0]  base_color;
  logic [4:0]  s;
  logic        is_glyph;
  logic        out_free;
  logic        s1_adv;
  logic [PROD_W-1:0] prod_x;
  logic [PROD_W-1:0] prod_y;
  out_item_t   result;

  function automatic cursor_t in_item_first_sel(logic f, cursor_t cur, cursor_t org);
    return f ? org : cur;
  endfunction

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x <= '0;
      origin_y <= '0;
      scale    <= 5'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ORIGIN_X: origin_x <= cfg_data;
        CFG_ORIGIN_Y: origin_y <= cfg_data;
        CFG_SCALE:    scale    <= cfg_data[4:0];
        default:      ;
      endcase
    end
  end

  glc_decode u_decode (
    .code_point (s1_item.code_point),
    .dec        (dec)
  );

  // Handshake: a drawing item needs room in the output register.
  assign is_glyph = (dec.kind == KIND_GLYPH);
  assign out_free = !out_valid || out_ready;
  assign s1_adv   = s1_valid && (!is_glyph || out_free);
  assign in_ready = !s1_valid || s1_adv;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_item <= in_item;
    end
  end

  // Start of label and scale clamp.
  always_comb begin
    base_x     = in_item_first_sel(s1_item.first, cursor_x, CURSOR_BITS'(origin_x));
    base_y     = in_item_first_sel(s1_item.first, cursor_y, CURSOR_BITS'(origin_y));
    base_color = s1_item.first ? INK_WHITE : current_color;
    if (scale == 5'd0) begin
      s = 5'd1;
    end else if (scale > 5'd16) begin
      s = 5'd16;
    end else begin
      s = scale;
    end
  end

  // Cursor and colour update.
  always_comb begin
    cursor_x_next      = base_x;
    cursor_y_next      = base_y;
    current_color_next = base_color;
    case (dec.kind)
      KIND_NEWLINE: begin
        cursor_x_next = CURSOR_BITS'(origin_x);
        cursor_y_next = sat_add(base_y, STEP_NEWLINE);
      end
      KIND_SPACE:  cursor_x_next = sat_add(base_x, STEP_SPACE);
      KIND_TAB:    cursor_x_next = sat_add(base_x, STEP_TAB);
      KIND_MARKER: current_color_next = dec.color;
      KIND_GLYPH:  cursor_x_next = sat_add(base_x, dec.wide ? STEP_WIDE : STEP_NARROW);
      default:     ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x      <= '0;
      cursor_y      <= '0;
      current_color <= INK_WHITE;
    end else if (s1_adv) begin
      cursor_x      <= cursor_x_next;
      cursor_y      <= cursor_y_next;
      current_color <= current_color_next;
    end
  end

  // Blit command fields.
  always_comb begin
    prod_x             = PROD_W'(base_x) * PROD_W'(s);
    prod_y             = PROD_W'(base_y) * PROD_W'(s);
    result.glyph_index = dec.glyph;
    result.src_x       = SRC_X_BASE + {1'b0, dec.glyph, 3'b000};
    result.dst_x       = prod_x[19:0];
    result.dst_y       = prod_y[19:0];
    result.dst_w       = {s, 3'b000};
    result.dst_h       = 7'({s, 2'b00}) + 7'({s, 1'b0});
    result.color_index = base_color;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid && is_glyph;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid && is_glyph) begin
      out_item <= result;
    end
  end

endmodule

// File: rtl/glc_checker.sv
module glc_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input glc_pkg::out_item_t out_item
);
  import glc_pkg::*;

  // A stalled command stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("stalled command changed or vanished");

  // Reset leaves no command pending.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("command shown straight after reset");

  // Source x follows from the glyph number, which stays in the atlas.
  a_src_x: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_item.src_x == SRC_X_BASE + {1'b0, out_item.glyph_index, 3'b000})
                  && (out_item.glyph_index <= 7'd80))
    else $error("source x does not match glyph index");

  // Width and height come from one clamped scale.
  a_rect: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_item.dst_w[2:0] == 3'b000) && (out_item.dst_w[7:3] != 5'd0)
                  && (out_item.dst_w[7:3] <= 5'd16)
                  && ((7'(out_item.dst_w[7:3]) * 7'd6) == out_item.dst_h))
    else $error("destination size is not a valid scale");

endmodule

bind glyph_layout_cursor_unit glc_checker u_glc_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);
